// ===== rtl/xxh_pkg.sv =====
// Shared constants, types and helper functions for the xxHash64 digest.
package xxh_pkg;

  localparam logic [63:0] P1 = 64'h9E3779B185EBCA87;
  localparam logic [63:0] P2 = 64'hC2B2AE3D27D4EB4F;
  localparam logic [63:0] P3 = 64'h165667B19E3779F9;
  localparam logic [63:0] P4 = 64'h85EBCA77C2B2AE63;
  localparam logic [63:0] P5 = 64'h27D4EB2F165667C5;
  localparam logic [63:0] P1_P2 = P1 + P2;

  localparam logic [5:0] ROT_ROUND = 6'd31;
  localparam logic [5:0] ROT_FOLD8 = 6'd27;
  localparam logic [5:0] ROT_FOLD4 = 6'd23;
  localparam logic [5:0] ROT_BYTE  = 6'd11;
  localparam logic [5:0] SHR_AV1   = 6'd33;
  localparam logic [5:0] SHR_AV2   = 6'd29;
  localparam logic [5:0] SHR_AV3   = 6'd32;

  localparam logic [3:0] WORD_BYTES = 4'd8;
  localparam logic [3:0] HALF_BYTES = 4'd4;

  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
  } mul_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] p;
  } mul_rsp_t;

  function automatic logic [63:0] rotl64(input logic [63:0] v, input logic [5:0] r);
    rotl64 = (v << r) | (v >> (7'd64 - {1'b0, r}));
  endfunction

  function automatic logic [5:0] merge_rot(input logic [1:0] idx);
    case (idx)
      2'd0:    merge_rot = 6'd1;
      2'd1:    merge_rot = 6'd7;
      2'd2:    merge_rot = 6'd12;
      default: merge_rot = 6'd18;
    endcase
  endfunction

  function automatic logic [63:0] lane_init(input logic [63:0] s, input logic [1:0] idx);
    case (idx)
      2'd0:    lane_init = s + P1_P2;
      2'd1:    lane_init = s + P2;
      2'd2:    lane_init = s;
      default: lane_init = s - P1;
    endcase
  endfunction

endpackage

// ===== rtl/xxh_mul.sv =====
// Shared iterative 64x64 multiplier, low 64 bits, one 32x32 partial product per cycle.
module xxh_mul (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  xxh_pkg::mul_req_t req_i,
  output xxh_pkg::mul_rsp_t rsp_o
);

  logic        busy_q;
  logic [1:0]  step_q;
  logic        done_q;
  logic [63:0] a_q;
  logic [63:0] b_q;
  logic [63:0] prod_q;
  logic [63:0] acc_q;
  logic [31:0] op_x;
  logic [31:0] op_y;
  logic [63:0] prod_d;

  always_comb begin
    case (step_q)
      2'd0: begin
        op_x = a_q[31:0];
        op_y = b_q[31:0];
      end
      2'd1: begin
        op_x = a_q[31:0];
        op_y = b_q[63:32];
      end
      2'd2: begin
        op_x = a_q[63:32];
        op_y = b_q[31:0];
      end
      default: begin
        op_x = a_q[31:0];
        op_y = b_q[31:0];
      end
    endcase
    prod_d = op_x * op_y;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= 2'd0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        step_q <= 2'd0;
      end else if (busy_q) begin
        step_q <= step_q + 2'd1;
        if (step_q == 2'd3) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q <= req_i.a;
      b_q <= req_i.b;
    end else if (busy_q) begin
      prod_q <= prod_d;
      case (step_q)
        2'd1:    acc_q <= prod_q;
        2'd2:    acc_q <= acc_q + {prod_q[31:0], 32'h0};
        2'd3:    acc_q <= acc_q + {prod_q[31:0], 32'h0};
        default: acc_q <= acc_q;
      endcase
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.p    = acc_q;

endmodule

// ===== rtl/xxhash64_stream_digest.sv =====
// Top level: xxHash64 over a stream of 64-bit words, sequencer around a shared multiplier.
//
//  channel   | handshake                 | payload
//  ----------+---------------------------+---------------------------------------
//  input     | in_valid_i / in_ready_o   | data_word_i, byte_count_i, last_i
//  output    | out_valid_o / out_ready_i | hash_value_o
//  seed      | seed_we_i (no wait)       | seed_i
//
//  Each 64-bit multiply goes through the shared multiplier, start to result.
//  A word that only fills the stripe buffer is stored; one that completes a stripe
//  runs two multiplies per lane, four lanes. A last word that completes a stripe
//  runs that round first, then the lane merge if a stripe was seen, one fold per
//  held word, the 4-byte step, one step per tail byte and the final avalanche.
//  in_ready_o is low while a word is in work; a finished hash waits in the output
//  register and only the next hash stalls on it. Reset returns seed 0 and fresh lanes.
module xxhash64_stream_digest (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        seed_we_i,
  input  logic [63:0] seed_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [63:0] data_word_i,
  input  logic [3:0]  byte_count_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] hash_value_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MIX_START,
    ST_MIX_A,
    ST_MIX_B,
    ST_MIX_C,
    ST_SUM,
    ST_ADD_LEN,
    ST_TAIL4,
    ST_T4_A,
    ST_T4_B,
    ST_BYTE,
    ST_BYTE_A,
    ST_BYTE_B,
    ST_AVAL_A,
    ST_AVAL_B,
    ST_FINISH
  } state_e;

  typedef enum logic [1:0] {
    MODE_ROUND,
    MODE_MERGE,
    MODE_FOLD
  } mode_e;

  state_e            state_q, state_d;
  mode_e             mode_q, mode_d;
  logic [1:0]        idx_q, idx_d;
  logic [1:0]        fcnt_q, fcnt_d;
  logic [3:0]        nb_q, nb_d;
  logic              last_q, last_d;
  logic [63:0]       seed_q, seed_d;
  logic [63:0]       lane_q [4];
  logic [63:0]       lane_d [4];
  logic [63:0]       total_q, total_d;
  logic [1:0]        wcnt_q, wcnt_d;
  logic              seen_q, seen_d;
  logic              out_valid_q, out_valid_d;
  logic [63:0]       hash_q, hash_d;
  xxh_pkg::mul_req_t req_q, req_d;
  xxh_pkg::mul_rsp_t rsp;

  logic [63:0]       buf_q [3];
  logic [63:0]       word_q, word_d;
  logic [63:0]       h_q, h_d;
  logic              buf_we;
  logic [1:0]        buf_wa;

  logic              accept;
  logic [3:0]        nsat;
  logic [63:0]       buf_rd;
  logic [63:0]       mix_src;
  logic [63:0]       mix_acc;
  logic [63:0]       hx;

  xxh_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_q),
    .rsp_o  (rsp)
  );

  assign in_ready_o   = (state_q == ST_IDLE);
  assign accept       = in_valid_i && in_ready_o;
  assign out_valid_o  = out_valid_q;
  assign hash_value_o = hash_q;
  assign nsat         = (byte_count_i > xxh_pkg::WORD_BYTES) ? xxh_pkg::WORD_BYTES
                                                               : byte_count_i;

  always_comb begin
    case (idx_q)
      2'd0:    buf_rd = buf_q[0];
      2'd1:    buf_rd = buf_q[1];
      default: buf_rd = buf_q[2];
    endcase
    case (mode_q)
      MODE_ROUND: mix_src = (idx_q == 2'd3) ? word_q : buf_rd;
      MODE_MERGE: mix_src = lane_q[idx_q];
      default:    mix_src = buf_rd;
    endcase
    mix_acc = (mode_q == MODE_ROUND) ? lane_q[idx_q] : 64'h0;
    hx      = h_q ^ rsp.p;
  end

  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    idx_d       = idx_q;
    fcnt_d      = fcnt_q;
    nb_d        = nb_q;
    last_d      = last_q;
    seed_d      = seed_q;
    lane_d      = lane_q;
    total_d     = total_q;
    wcnt_d      = wcnt_q;
    seen_d      = seen_q;
    out_valid_d = out_valid_q;
    hash_d      = hash_q;
    req_d       = req_q;
    req_d.start = 1'b0;
    word_d      = word_q;
    h_d         = h_q;
    buf_we      = 1'b0;
    buf_wa      = wcnt_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          word_d = data_word_i;
          last_d = last_i;
          mode_d = MODE_ROUND;
          idx_d  = 2'd0;
          if (!last_i) begin
            total_d = total_q + {60'h0, xxh_pkg::WORD_BYTES};
            if (wcnt_q != 2'd3) begin
              buf_we = 1'b1;
              wcnt_d = wcnt_q + 2'd1;
            end else begin
              state_d = ST_MIX_START;
            end
          end else begin
            total_d = total_q + {60'h0, nsat};
            if (nsat == xxh_pkg::WORD_BYTES && wcnt_q == 2'd3) begin
              nb_d    = 4'd0;
              fcnt_d  = 2'd0;
              state_d = ST_MIX_START;
            end else begin
              if (nsat == xxh_pkg::WORD_BYTES) begin
                buf_we = 1'b1;
                nb_d   = 4'd0;
                fcnt_d = wcnt_q + 2'd1;
              end else begin
                nb_d   = nsat;
                fcnt_d = wcnt_q;
              end
              if (seen_q) begin
                state_d = ST_SUM;
              end else begin
                h_d     = seed_q + xxh_pkg::P5;
                state_d = ST_ADD_LEN;
              end
            end
          end
        end
      end

      ST_MIX_START: begin
        req_d.start = 1'b1;
        req_d.a     = mix_src;
        req_d.b     = xxh_pkg::P2;
        state_d     = ST_MIX_A;
      end

      ST_MIX_A: begin
        if (rsp.done) begin
          req_d.start = 1'b1;
          req_d.a     = xxh_pkg::rotl64(mix_acc + rsp.p, xxh_pkg::ROT_ROUND);
          req_d.b     = xxh_pkg::P1;
          state_d     = ST_MIX_B;
        end
      end

      ST_MIX_B: begin
        if (rsp.done) begin
          case (mode_q)
            MODE_ROUND: begin
              lane_d[idx_q] = rsp.p;
              if (idx_q == 2'd3) begin
                wcnt_d = 2'd0;
                seen_d = 1'b1;
                idx_d  = 2'd0;
                state_d = last_q ? ST_SUM : ST_IDLE;
              end else begin
                idx_d   = idx_q + 2'd1;
                state_d = ST_MIX_START;
              end
            end
            MODE_MERGE: begin
              req_d.start = 1'b1;
              req_d.a     = hx;
              req_d.b     = xxh_pkg::P1;
              state_d     = ST_MIX_C;
            end
            default: begin
              req_d.start = 1'b1;
              req_d.a     = xxh_pkg::rotl64(hx, xxh_pkg::ROT_FOLD8);
              req_d.b     = xxh_pkg::P1;
              state_d     = ST_MIX_C;
            end
          endcase
        end
      end

      ST_MIX_C: begin
        if (rsp.done) begin
          h_d = rsp.p + xxh_pkg::P4;
          if (mode_q == MODE_MERGE) begin
            if (idx_q == 2'd3) begin
              idx_d   = 2'd0;
              state_d = ST_ADD_LEN;
            end else begin
              idx_d   = idx_q + 2'd1;
              state_d = ST_MIX_START;
            end
          end else begin
            if (idx_q == fcnt_q - 2'd1) begin
              state_d = ST_TAIL4;
            end else begin
              idx_d   = idx_q + 2'd1;
              state_d = ST_MIX_START;
            end
          end
        end
      end

      ST_SUM: begin
        h_d = ((idx_q == 2'd0) ? 64'h0 : h_q) +
              xxh_pkg::rotl64(lane_q[idx_q], xxh_pkg::merge_rot(idx_q));
        if (idx_q == 2'd3) begin
          idx_d   = 2'd0;
          mode_d  = MODE_MERGE;
          state_d = ST_MIX_START;
        end else begin
          idx_d = idx_q + 2'd1;
        end
      end

      ST_ADD_LEN: begin
        h_d = h_q + total_q;
        if (fcnt_q != 2'd0) begin
          mode_d  = MODE_FOLD;
          idx_d   = 2'd0;
          state_d = ST_MIX_START;
        end else begin
          state_d = ST_TAIL4;
        end
      end

      ST_TAIL4: begin
        if (nb_q >= xxh_pkg::HALF_BYTES) begin
          req_d.start = 1'b1;
          req_d.a     = {32'h0, word_q[31:0]};
          req_d.b     = xxh_pkg::P1;
          state_d     = ST_T4_A;
        end else begin
          state_d = ST_BYTE;
        end
      end

      ST_T4_A: begin
        if (rsp.done) begin
          req_d.start = 1'b1;
          req_d.a     = xxh_pkg::rotl64(hx, xxh_pkg::ROT_FOLD4);
          req_d.b     = xxh_pkg::P2;
          state_d     = ST_T4_B;
        end
      end

      ST_T4_B: begin
        if (rsp.done) begin
          h_d     = rsp.p + xxh_pkg::P3;
          word_d  = word_q >> 32;
          nb_d    = nb_q - xxh_pkg::HALF_BYTES;
          state_d = ST_BYTE;
        end
      end

      ST_BYTE: begin
        req_d.start = 1'b1;
        if (nb_q != 4'd0) begin
          req_d.a = {56'h0, word_q[7:0]};
          req_d.b = xxh_pkg::P5;
          state_d = ST_BYTE_A;
        end else begin
          req_d.a = h_q ^ (h_q >> xxh_pkg::SHR_AV1);
          req_d.b = xxh_pkg::P2;
          state_d = ST_AVAL_A;
        end
      end

      ST_BYTE_A: begin
        if (rsp.done) begin
          req_d.start = 1'b1;
          req_d.a     = xxh_pkg::rotl64(hx, xxh_pkg::ROT_BYTE);
          req_d.b     = xxh_pkg::P1;
          state_d     = ST_BYTE_B;
        end
      end

      ST_BYTE_B: begin
        if (rsp.done) begin
          h_d     = rsp.p;
          word_d  = word_q >> 8;
          nb_d    = nb_q - 4'd1;
          state_d = ST_BYTE;
        end
      end

      ST_AVAL_A: begin
        if (rsp.done) begin
          req_d.start = 1'b1;
          req_d.a     = rsp.p ^ (rsp.p >> xxh_pkg::SHR_AV2);
          req_d.b     = xxh_pkg::P3;
          state_d     = ST_AVAL_B;
        end
      end

      ST_AVAL_B: begin
        if (rsp.done) begin
          h_d     = rsp.p ^ (rsp.p >> xxh_pkg::SHR_AV3);
          state_d = ST_FINISH;
        end
      end

      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          hash_d      = h_q;
          out_valid_d = 1'b1;
          for (int i = 0; i < 4; i++) begin
            lane_d[i] = xxh_pkg::lane_init(seed_q, i[1:0]);
          end
          wcnt_d  = 2'd0;
          total_d = 64'h0;
          seen_d  = 1'b0;
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase

    // restart the digest under the new seed
    if (seed_we_i) begin
      seed_d = seed_i;
      for (int i = 0; i < 4; i++) begin
        lane_d[i] = xxh_pkg::lane_init(seed_i, i[1:0]);
      end
      wcnt_d  = 2'd0;
      total_d = 64'h0;
      seen_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mode_q      <= MODE_ROUND;
      idx_q       <= 2'd0;
      fcnt_q      <= 2'd0;
      nb_q        <= 4'd0;
      last_q      <= 1'b0;
      seed_q      <= 64'h0;
      for (int i = 0; i < 4; i++) begin
        lane_q[i] <= xxh_pkg::lane_init(64'h0, i[1:0]);
      end
      total_q     <= 64'h0;
      wcnt_q      <= 2'd0;
      seen_q      <= 1'b0;
      out_valid_q <= 1'b0;
      hash_q      <= 64'h0;
      req_q       <= '0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      idx_q       <= idx_d;
      fcnt_q      <= fcnt_d;
      nb_q        <= nb_d;
      last_q      <= last_d;
      seed_q      <= seed_d;
      lane_q      <= lane_d;
      total_q     <= total_d;
      wcnt_q      <= wcnt_d;
      seen_q      <= seen_d;
      out_valid_q <= out_valid_d;
      hash_q      <= hash_d;
      req_q       <= req_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
    h_q    <= h_d;
    if (buf_we) begin
      buf_q[buf_wa] <= data_word_i;
    end
  end

endmodule

// ===== rtl/xxh_checker.sv =====
// Port-level checks on the xxHash64 digest, bound to the top level.
module xxh_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        last_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [63:0] hash_value_o
);

  // drop ready after the last beat of a message
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && last_i |=> !in_ready_o)
    else $error("input ready stayed high after last beat");

  // a new hash only appears at the end of a busy stretch
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("hash appeared without a busy cycle before it");

  // hold a stalled hash
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(hash_value_o))
    else $error("stalled hash dropped or changed");

endmodule

bind xxhash64_stream_digest xxh_checker u_xxh_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .last_i       (last_i),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .hash_value_o (hash_value_o)
);

// ===== dv/testbench.sv =====
// Self-checking bench for the xxHash64 word-stream digest: directed table, then random messages.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES = 400;
  localparam int HOLD_CYCLES   = 600;
  localparam int PHASE_BEATS   = 150;

  typedef struct packed {
    logic [63:0] data;
    logic [3:0]  cnt;
    logic        fin;
    logic        known;
    logic [63:0] hash;
  } vec_t;

  logic        clk_i;
  logic        rst_ni;
  logic        seed_we_i;
  logic [63:0] seed_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [63:0] data_word_i;
  logic [3:0]  byte_count_i;
  logic        last_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [63:0] hash_value_o;

  logic [63:0] seed_q;
  logic [63:0] lane_acc [4];
  logic [63:0] held_word [3];
  int unsigned held_n;
  logic [63:0] byte_total;
  logic        stripe_seen;

  logic [63:0] hash_q [$];
  int          faults;
  int          beats;
  bit          send_calm;
  bit          recv_calm;
  bit          hold_req;

  vec_t directed_tbl [23] = '{
    '{64'h0000000000000000, 4'd0,  1'b1, 1'b1, 64'hEF46DB3751D8E999},
    '{64'hFFFFFFFFFFFFFFFF, 4'd15, 1'b1, 1'b0, 64'h0},
    '{64'h0000000000000000, 4'd9,  1'b1, 1'b0, 64'h0},
    '{64'h0123456789ABCDEF, 4'd5,  1'b0, 1'b0, 64'h0},
    '{64'hFFFFFFFFFFFFFFFF, 4'd7,  1'b1, 1'b0, 64'h0},
    '{64'h8000000000000000, 4'd0,  1'b0, 1'b0, 64'h0},
    '{64'h0000000000000001, 4'd8,  1'b0, 1'b0, 64'h0},
    '{64'hAAAAAAAAAAAAAAAA, 4'd3,  1'b0, 1'b0, 64'h0},
    '{64'h5555555555555555, 4'd8,  1'b1, 1'b0, 64'h0},
    '{64'hFEDCBA9876543210, 4'd0,  1'b0, 1'b0, 64'h0},
    '{64'hFFFFFFFFFFFFFFFF, 4'd15, 1'b0, 1'b0, 64'h0},
    '{64'h0000000000000000, 4'd8,  1'b0, 1'b0, 64'h0},
    '{64'h7FFFFFFFFFFFFFFF, 4'd1,  1'b0, 1'b0, 64'h0},
    '{64'h0F1E2D3C4B5A6978, 4'd8,  1'b1, 1'b0, 64'h0},
    '{64'h1111111111111111, 4'd2,  1'b0, 1'b0, 64'h0},
    '{64'h2222222222222222, 4'd4,  1'b0, 1'b0, 64'h0},
    '{64'h3333333333333333, 4'd6,  1'b0, 1'b0, 64'h0},
    '{64'h4444444444444444, 4'd8,  1'b0, 1'b0, 64'h0},
    '{64'hDEADBEEFCAFEF00D, 4'd4,  1'b1, 1'b0, 64'h0},
    '{64'hFFFFFFFFFFFFFF80, 4'd1,  1'b1, 1'b0, 64'h0},
    '{64'hFFFFFFFFFFFF00FF, 4'd2,  1'b1, 1'b0, 64'h0},
    '{64'hFF00123456789ABC, 4'd6,  1'b1, 1'b0, 64'h0},
    '{64'hFFFFFFFFFFFFFFFF, 4'd0,  1'b1, 1'b1, 64'hEF46DB3751D8E999}
  };

  xxhash64_stream_digest uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .seed_we_i    (seed_we_i),
    .seed_i       (seed_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .data_word_i  (data_word_i),
    .byte_count_i (byte_count_i),
    .last_i       (last_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .hash_value_o (hash_value_o)
  );

  function automatic logic [63:0] rot_left(input logic [63:0] v, input int r);
    return (v << r) | (v >> (64 - r));
  endfunction

  function automatic logic [63:0] lane_round(input logic [63:0] acc, input logic [63:0] w);
    logic [63:0] t;
    t = acc + w * xxh_pkg::P2;
    t = rot_left(t, int'(xxh_pkg::ROT_ROUND));
    return t * xxh_pkg::P1;
  endfunction

  function automatic logic [63:0] fold_word(input logic [63:0] h, input logic [63:0] w);
    logic [63:0] t;
    t = h ^ lane_round(64'h0, w);
    t = rot_left(t, int'(xxh_pkg::ROT_FOLD8));
    return t * xxh_pkg::P1 + xxh_pkg::P4;
  endfunction

  function automatic logic [63:0] scramble(input logic [63:0] h);
    logic [63:0] t;
    t = h ^ (h >> xxh_pkg::SHR_AV1);
    t = t * xxh_pkg::P2;
    t = t ^ (t >> xxh_pkg::SHR_AV2);
    t = t * xxh_pkg::P3;
    return t ^ (t >> xxh_pkg::SHR_AV3);
  endfunction

  function automatic void digest_restart();
    lane_acc[0] = seed_q + xxh_pkg::P1 + xxh_pkg::P2;
    lane_acc[1] = seed_q + xxh_pkg::P2;
    lane_acc[2] = seed_q;
    lane_acc[3] = seed_q - xxh_pkg::P1;
    held_n      = 0;
    byte_total  = 64'h0;
    stripe_seen = 1'b0;
  endfunction

  function automatic void digest_take(input logic [63:0] w);
    if (held_n < 3) begin
      held_word[held_n] = w;
      held_n++;
    end else begin
      lane_acc[0] = lane_round(lane_acc[0], held_word[0]);
      lane_acc[1] = lane_round(lane_acc[1], held_word[1]);
      lane_acc[2] = lane_round(lane_acc[2], held_word[2]);
      lane_acc[3] = lane_round(lane_acc[3], w);
      held_n      = 0;
      stripe_seen = 1'b1;
    end
  endfunction

  function automatic bit digest_step(input logic [63:0] w_in, input logic [3:0] cnt_in,
                                     input logic fin, output logic [63:0] hash);
    logic [63:0] h;
    logic [63:0] w;
    int          n;
    w = w_in;
    hash = 64'h0;
    if (!fin) begin
      digest_take(w);
      byte_total += 64'd8;
      return 1'b0;
    end
    n = (cnt_in > 4'd8) ? 8 : int'(cnt_in);
    byte_total += 64'(n);
    if (n == 8) begin
      digest_take(w);
      n = 0;
      if (held_n != 0) begin
        held_n--;
        n = 8;
      end
    end
    if (stripe_seen) begin
      h = rot_left(lane_acc[0], 1) + rot_left(lane_acc[1], 7) +
          rot_left(lane_acc[2], 12) + rot_left(lane_acc[3], 18);
      for (int i = 0; i < 4; i++) begin
        h = h ^ lane_round(64'h0, lane_acc[i]);
        h = h * xxh_pkg::P1 + xxh_pkg::P4;
      end
    end else begin
      h = seed_q + xxh_pkg::P5;
    end
    h += byte_total;
    for (int i = 0; i < held_n; i++) h = fold_word(h, held_word[i]);
    if (n == 8) begin
      h = fold_word(h, w);
    end else begin
      if (n >= 4) begin
        h = h ^ ({32'h0, w[31:0]} * xxh_pkg::P1);
        h = rot_left(h, int'(xxh_pkg::ROT_FOLD4));
        h = h * xxh_pkg::P2 + xxh_pkg::P3;
        w = w >> 32;
        n -= 4;
      end
      while (n != 0) begin
        h = h ^ ({56'h0, w[7:0]} * xxh_pkg::P5);
        h = rot_left(h, int'(xxh_pkg::ROT_BYTE));
        h = h * xxh_pkg::P1;
        w = w >> 8;
        n--;
      end
    end
    hash = scramble(h);
    digest_restart();
    return 1'b1;
  endfunction

  function automatic logic [63:0] rand_word();
    case ($urandom_range(0, 15))
      0:       return 64'h0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic log_fault(input string what, input logic [63:0] want, input logic [63:0] got);
    if (faults < 10) $display("%0t %s: expected %h got %h", $time, what, want, got);
    faults++;
  endtask

  task automatic send_beat(input logic [63:0] data, input logic [3:0] cnt, input logic fin,
                           input logic known, input logic [63:0] typed);
    int          gap;
    logic [63:0] h;
    gap = send_calm ? 0 : $urandom_range(0, 16);
    if (gap != 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    data_word_i  = data;
    byte_count_i = cnt;
    last_i       = fin;
    in_valid_i   = 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (digest_step(data, cnt, fin, h)) hash_q.push_back(known ? typed : h);
    beats++;
    @(negedge clk_i);
  endtask

  task automatic send_message();
    int words;
    int sel;
    sel   = $urandom_range(0, 99);
    words = (sel < 70) ? $urandom_range(1, 8) :
            (sel < 95) ? $urandom_range(9, 20) : $urandom_range(21, 40);
    for (int i = 1; i < words; i++) begin
      send_beat(rand_word(), 4'($urandom_range(0, 15)), 1'b0, 1'b0, 64'h0);
    end
    send_beat(rand_word(),
              ($urandom_range(0, 4) == 0) ? 4'($urandom_range(9, 15))
                                          : 4'($urandom_range(0, 8)),
              1'b1, 1'b0, 64'h0);
  endtask

  // drain: wait out every pending digest, then the worst-case word latency
  task automatic settle();
    in_valid_i = 1'b0;
    while (hash_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic load_seed(input logic [63:0] v);
    seed_i    = v;
    seed_we_i = 1'b1;
    @(negedge clk_i);
    seed_we_i = 1'b0;
    seed_q    = v;
    digest_restart();
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #15_000_000;
    $display("testbench: errors");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (hash_q.size() == 0) begin
        log_fault("hash with no message pending", 64'h0, hash_value_o);
      end else begin
        if (hash_value_o !== hash_q[0]) log_fault("hash_value", hash_q[0], hash_value_o);
        void'(hash_q.pop_front());
      end
    end
  end

  initial begin
    int stall;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (hold_req) begin
        out_ready_i = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
      end
      stall = recv_calm ? 0 : $urandom_range(0, 16);
      if (stall != 0) begin
        out_ready_i = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i = 1'b1;
      @(posedge clk_i);
      while (!out_valid_o && !hold_req) @(posedge clk_i);
      @(negedge clk_i);
    end
  end

  initial begin
    logic [63:0] seeds [7];
    int          base;
    rst_ni       = 1'b0;
    seed_we_i    = 1'b0;
    seed_i       = 64'h0;
    in_valid_i   = 1'b0;
    data_word_i  = 64'h0;
    byte_count_i = 4'd0;
    last_i       = 1'b0;
    faults       = 0;
    beats        = 0;
    send_calm    = 1'b0;
    recv_calm    = 1'b0;
    hold_req     = 1'b0;
    seed_q       = 64'h0;
    for (int i = 0; i < 3; i++) held_word[i] = 64'h0;
    digest_restart();
    seeds = '{64'hFFFFFFFFFFFFFFFF, {$urandom, $urandom}, 64'h1, xxh_pkg::P1,
              64'h8000000000000000, {$urandom, $urandom}, 64'h0};

    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (directed_tbl[i]) begin
      send_beat(directed_tbl[i].data, directed_tbl[i].cnt, directed_tbl[i].fin,
                directed_tbl[i].known, directed_tbl[i].hash);
    end

    for (int p = 0; p < 7; p++) begin
      settle();
      send_calm = (p == 2);
      recv_calm = (p == 4);
      // seed change in the middle of a message restarts the digest
      if (p == 3) begin
        repeat (5) send_beat(rand_word(), 4'($urandom_range(0, 15)), 1'b0, 1'b0, 64'h0);
        settle();
      end
      load_seed(seeds[p]);
      if (p == 1) begin
        hold_req = 1'b1;
        repeat (8) send_beat(rand_word(), 4'($urandom_range(0, 8)), 1'b1, 1'b0, 64'h0);
      end
      base = beats;
      while (beats - base < PHASE_BEATS) send_message();
    end

    in_valid_i = 1'b0;
    while (hash_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    faults += hash_q.size();
    if (faults == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/xxh_pkg.sv
rtl/xxh_mul.sv
rtl/xxhash64_stream_digest.sv
rtl/xxh_checker.sv
dv/testbench.sv
